// File: hw/rtl/dc_fan_motor_derivative_assert.svh
`ifndef DC_FAN_MOTOR_DERIVATIVE_ASSERT_SVH
`define DC_FAN_MOTOR_DERIVATIVE_ASSERT_SVH

// Checks that are not evaluated while reset is applied.
`define DCFM_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dcfm check failed");

// Checks that hold at every edge, reset included.
`define DCFM_CHECK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dcfm check failed");

`endif

// File: hw/rtl/dcfm_pkg.sv
package dcfm_pkg;

  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegNomSpeed  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegNomVolt   = 8'd1;
  localparam logic [CfgIdxW-1:0] RegArmRes    = 8'd2;
  localparam logic [CfgIdxW-1:0] RegFlux      = 8'd3;
  localparam logic [CfgIdxW-1:0] RegInertia   = 8'd4;
  localparam logic [CfgIdxW-1:0] RegDrag      = 8'd5;
  localparam logic [CfgIdxW-1:0] RegSndPower  = 8'd6;
  localparam logic [CfgIdxW-1:0] RegSndPitch  = 8'd7;

  localparam logic [20:0] RstNomSpeed = 21'd193024;
  localparam logic [14:0] RstNomVolt  = 15'd12000;
  localparam logic [19:0] RstArmRes   = 20'd9421;
  localparam logic [19:0] RstFlux     = 20'd7076;
  localparam logic [19:0] RstInertia  = 20'd2048;
  localparam logic [19:0] RstDrag     = 20'd4404;
  localparam logic [15:0] RstPitch    = 16'd8192;

endpackage

// File: hw/rtl/dc_fan_motor_derivative.sv
// DC fan motor derivative unit. Each item (supply voltage, rotor speed) yields one result
// item: acceleration, armature current, powered/ready/sound flags and pitch. The block
// works on one item at a time; the next item can be accepted in the cycle after a result
// is loaded into the output register. The work is done by the bit-serial units: one
// 64-step restoring divider used four times, one 24-step square root and one 24-step
// shift-add multiplier used five times. A new item is taken while the previous result
// still waits in the output register. Configuration is to be written through the cfg
// port only while the block is idle; the block does not enforce this, and cfg_ready is
// always high.
module dc_fan_motor_derivative (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            in_supply_voltage,
  input  logic signed [21:0]            in_rotor_speed,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_acceleration,
  output logic signed [23:0]            out_current,
  output logic                          out_powered,
  output logic                          out_ready_res,
  output logic                          out_sound_on,
  output logic signed [15:0]            out_pitch,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dcfm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [dcfm_pkg::CfgDataW-1:0] cfg_data
);
  import dcfm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIVQ, S_SQRT, S_MCPHI, S_MCW, S_DCUR, S_MMA, S_MWW, S_MMR,
    S_DACC, S_DPIT, S_DONE
  } state_t;

  state_t      state_r;
  logic [5:0]  cnt_r;

  logic [20:0] speed_r;
  logic [14:0] volt_r;
  logic [19:0] res_r, flux_r, inert_r, drag_r;
  logic        snd_pow_r, snd_pitch_r;
  logic [15:0] held_r;

  logic [15:0] u_r;
  logic [21:0] w_r;
  logic [37:0] cphi_r;
  logic [63:0] ma_r;
  logic        sgn_r;
  logic [23:0] cur_r;
  logic [31:0] acc_r;

  logic [43:0] mul_a_r;
  logic [23:0] mul_b_r;
  logic [44:0] mul_hi_r;
  logic [63:0] dvd_r;
  logic [31:0] rem_r, dvs_r;
  logic [47:0] rad_r;
  logic [25:0] srem_r;
  logic [23:0] root_r;

  logic [44:0] mul_sum, mul_hi_step;
  logic [23:0] mul_b_step;
  logic [63:0] mul_prod;
  logic [32:0] div_t, div_diff;
  logic        div_ge;
  logic [31:0] rem_step;
  logic [63:0] dvd_step;
  logic [27:0] sq_t, sq_trial, sq_diff;
  logic        sq_ge;
  logic [25:0] srem_step;
  logic [23:0] root_step;

  logic [21:0] wa;
  logic        w_neg, powered;
  logic [20:0] om;
  logic [14:0] volt_nz;
  logic [19:0] res_nz, inert_nz;
  logic [63:0] u_ext, num, num_mag, mr, diff, diff_mag;
  logic [63:0] cur_lim, acc_lim, pit_lim;
  logic [23:0] cur_mag;
  logic [31:0] acc_mag;
  logic [15:0] pit_mag, pit_val;
  logic [26:0] w10, om9, w2, om27;
  logic        ready_f, snd_f;
  logic        last;
  logic        out_load;
  logic        in_div;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign last      = (cnt_r == 6'd0);
  assign out_load  = (state_r == S_DONE) && (!out_valid || !out_stall);
  assign in_div    = state_r inside {S_DIVQ, S_DCUR, S_DACC, S_DPIT};

  // Shift-add multiplier, one bit of the b operand per cycle.
  assign mul_sum     = mul_hi_r + (mul_b_r[0] ? {1'b0, mul_a_r} : 45'd0);
  assign mul_hi_step = {1'b0, mul_sum[44:1]};
  assign mul_b_step  = {mul_sum[0], mul_b_r[23:1]};
  assign mul_prod    = {mul_hi_step[39:0], mul_b_step};

  // Restoring divider, one quotient bit per cycle shifted into the dividend register.
  assign div_t    = {rem_r, dvd_r[63]};
  assign div_diff = div_t - {1'b0, dvs_r};
  assign div_ge   = (div_t >= {1'b0, dvs_r});
  assign rem_step = div_ge ? div_diff[31:0] : div_t[31:0];
  assign dvd_step = {dvd_r[62:0], div_ge};

  // Restoring square root, two radicand bits per cycle.
  assign sq_t      = {srem_r, rad_r[47:46]};
  assign sq_trial  = {2'b00, root_r, 2'b01};
  assign sq_ge     = (sq_t >= sq_trial);
  assign sq_diff   = sq_t - sq_trial;
  assign srem_step = sq_ge ? sq_diff[25:0] : sq_t[25:0];
  assign root_step = {root_r[22:0], sq_ge};

  assign w_neg    = w_r[21];
  assign wa       = w_neg ? (22'd0 - w_r) : w_r;
  assign powered  = !u_r[15] && (u_r != 16'd0);
  assign om       = (speed_r == 21'd0) ? 21'd1 : speed_r;
  assign volt_nz  = (volt_r == 15'd0) ? 15'd1 : volt_r;
  assign res_nz   = (res_r == 20'd0) ? 20'd1 : res_r;
  assign inert_nz = (inert_r == 20'd0) ? 20'd1 : inert_r;

  assign u_ext    = {{21{u_r[15]}}, u_r, 27'd0};
  assign num      = w_neg ? (u_ext + mul_prod) : (u_ext - mul_prod);
  assign num_mag  = num[63] ? (64'd0 - num) : num;
  assign mr       = {12'd0, mul_prod[63:12]};
  assign diff     = w_neg ? (ma_r + mr) : (ma_r - mr);
  assign diff_mag = diff[63] ? (64'd0 - diff) : diff;

  // Saturation works on the magnitude; the negative limit is one larger.
  assign cur_lim = sgn_r ? 64'd8388608 : 64'd8388607;
  assign acc_lim = sgn_r ? 64'd2147483648 : 64'd2147483647;
  assign pit_lim = sgn_r ? 64'd32768 : 64'd32767;
  assign cur_mag = (dvd_step > cur_lim) ? cur_lim[23:0] : dvd_step[23:0];
  assign acc_mag = (dvd_step > acc_lim) ? acc_lim[31:0] : dvd_step[31:0];
  assign pit_mag = (dvd_step > pit_lim) ? pit_lim[15:0] : dvd_step[15:0];
  assign pit_val = sgn_r ? (16'd0 - pit_mag) : pit_mag;

  assign w10     = {{2{w_r[21]}}, w_r, 3'd0} + {{4{w_r[21]}}, w_r, 1'b0};
  assign om27    = {6'd0, om};
  assign om9     = {3'd0, om, 3'd0} + om27;
  assign w2      = {{4{w_r[21]}}, w_r, 1'b0};
  assign ready_f = ($signed(w10) > $signed(om9));
  assign snd_f   = snd_pow_r ? powered : ($signed(w2) >= $signed(om27));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 6'd0;
      out_valid   <= 1'b0;
      speed_r     <= RstNomSpeed;
      volt_r      <= RstNomVolt;
      res_r       <= RstArmRes;
      flux_r      <= RstFlux;
      inert_r     <= RstInertia;
      drag_r      <= RstDrag;
      snd_pow_r   <= 1'b0;
      snd_pitch_r <= 1'b0;
      held_r      <= RstPitch;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegNomSpeed: speed_r     <= cfg_data[20:0];
          RegNomVolt:  volt_r      <= cfg_data[14:0];
          RegArmRes:   res_r       <= cfg_data[19:0];
          RegFlux:     flux_r      <= cfg_data[19:0];
          RegInertia:  inert_r     <= cfg_data[19:0];
          RegDrag:     drag_r      <= cfg_data[19:0];
          RegSndPower: snd_pow_r   <= cfg_data[0];
          RegSndPitch: snd_pitch_r <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            u_r   <= in_supply_voltage;
            w_r   <= in_rotor_speed;
            rem_r <= 32'd0;
            dvs_r <= {17'd0, volt_nz};
            cnt_r <= 6'd63;
            if (!in_supply_voltage[15] && (in_supply_voltage != 16'sd0)) begin
              dvd_r <= {17'd0, in_supply_voltage[14:0], 32'd0};
            end else begin
              dvd_r <= 64'd0;
            end
            state_r <= S_DIVQ;
          end
        end
        S_DIVQ: begin
          if (last) begin
            rad_r   <= dvd_step[47:0];
            srem_r  <= 26'd0;
            root_r  <= 24'd0;
            cnt_r   <= 6'd23;
            state_r <= S_SQRT;
          end else begin
            rem_r <= rem_step;
            dvd_r <= dvd_step;
            cnt_r <= cnt_r - 6'd1;
          end
        end
        S_SQRT: begin
          if (last) begin
            mul_a_r  <= {24'd0, flux_r};
            mul_b_r  <= root_step;
            mul_hi_r <= 45'd0;
            cnt_r    <= 6'd23;
            state_r  <= S_MCPHI;
          end else begin
            rad_r  <= {rad_r[45:0], 2'b00};
            srem_r <= srem_step;
            root_r <= root_step;
            cnt_r  <= cnt_r - 6'd1;
          end
        end
        S_MCPHI: begin
          if (last) begin
            // Without supply the flux is zero.
            cphi_r   <= powered ? mul_prod[43:6] : 38'd0;
            mul_a_r  <= powered ? {6'd0, mul_prod[43:6]} : 44'd0;
            mul_b_r  <= {2'b00, wa};
            mul_hi_r <= 45'd0;
            cnt_r    <= 6'd23;
            state_r  <= S_MCW;
          end else begin
            mul_hi_r <= mul_hi_step;
            mul_b_r  <= mul_b_step;
            cnt_r    <= cnt_r - 6'd1;
          end
        end
        S_MCW: begin
          if (last) begin
            dvd_r   <= num_mag;
            rem_r   <= 32'd0;
            dvs_r   <= {res_nz, 12'd0};
            sgn_r   <= num[63];
            cnt_r   <= 6'd63;
            state_r <= S_DCUR;
          end else begin
            mul_hi_r <= mul_hi_step;
            mul_b_r  <= mul_b_step;
            cnt_r    <= cnt_r - 6'd1;
          end
        end
        S_DCUR: begin
          if (last) begin
            cur_r    <= sgn_r ? (24'd0 - cur_mag) : cur_mag;
            mul_a_r  <= {6'd0, cphi_r};
            mul_b_r  <= cur_mag;
            mul_hi_r <= 45'd0;
            cnt_r    <= 6'd23;
            state_r  <= S_MMA;
          end else begin
            rem_r <= rem_step;
            dvd_r <= dvd_step;
            cnt_r <= cnt_r - 6'd1;
          end
        end
        S_MMA: begin
          if (last) begin
            ma_r     <= sgn_r ? (64'd0 - mul_prod) : mul_prod;
            mul_a_r  <= {22'd0, wa};
            mul_b_r  <= {2'b00, wa};
            mul_hi_r <= 45'd0;
            cnt_r    <= 6'd23;
            state_r  <= S_MWW;
          end else begin
            mul_hi_r <= mul_hi_step;
            mul_b_r  <= mul_b_step;
            cnt_r    <= cnt_r - 6'd1;
          end
        end
        S_MWW: begin
          if (last) begin
            mul_a_r  <= mul_prod[43:0];
            mul_b_r  <= {4'd0, drag_r};
            mul_hi_r <= 45'd0;
            cnt_r    <= 6'd23;
            state_r  <= S_MMR;
          end else begin
            mul_hi_r <= mul_hi_step;
            mul_b_r  <= mul_b_step;
            cnt_r    <= cnt_r - 6'd1;
          end
        end
        S_MMR: begin
          if (last) begin
            dvd_r   <= diff_mag;
            rem_r   <= 32'd0;
            dvs_r   <= {4'd0, inert_nz, 8'd0};
            sgn_r   <= diff[63];
            cnt_r   <= 6'd63;
            state_r <= S_DACC;
          end else begin
            mul_hi_r <= mul_hi_step;
            mul_b_r  <= mul_b_step;
            cnt_r    <= cnt_r - 6'd1;
          end
        end
        S_DACC: begin
          if (last) begin
            acc_r   <= sgn_r ? (32'd0 - acc_mag) : acc_mag;
            dvd_r   <= {29'd0, wa, 13'd0};
            rem_r   <= 32'd0;
            dvs_r   <= {11'd0, om};
            sgn_r   <= w_neg;
            cnt_r   <= 6'd63;
            state_r <= S_DPIT;
          end else begin
            rem_r <= rem_step;
            dvd_r <= dvd_step;
            cnt_r <= cnt_r - 6'd1;
          end
        end
        S_DPIT: begin
          if (last) begin
            if (snd_pitch_r) held_r <= pit_val;
            state_r <= S_DONE;
          end else begin
            rem_r <= rem_step;
            dvd_r <= dvd_step;
            cnt_r <= cnt_r - 6'd1;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_acceleration <= acc_r;
            out_current      <= cur_r;
            out_powered      <= powered;
            out_ready_res    <= ready_f;
            out_sound_on     <= snd_f;
            out_pitch        <= held_r;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`include "dc_fan_motor_derivative_assert.svh"

  `DCFM_CHECK(a_out_from_done, $rose(out_valid) |-> $past(state_r == S_DONE))
  `DCFM_CHECK(a_accept_starts, (in_valid && !in_stall) |=> (state_r == S_DIVQ))
  `DCFM_CHECK(a_div_nonzero, in_div |-> (dvs_r != 32'd0))
  `DCFM_CHECK(a_unpowered_flux, (state_r == S_MCW && !powered) |-> (cphi_r == 38'd0))

endmodule

// File: verif/dc_fan_motor_derivative_test.sv
`timescale 1ns / 100ps

module dc_fan_motor_derivative_test;
  import dcfm_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 8'd200;
  localparam int NumRandPhases = 7;
  localparam int RandPerPhase  = 263;
  localparam int HoldCycles    = 3000;

  typedef struct packed {
    logic signed [31:0] accel;
    logic signed [23:0] cur;
    logic               pwr;
    logic               rdy;
    logic               snd;
    logic signed [15:0] pitch;
  } motor_result_t;

  class motor_scoreboard;
    logic [20:0] nom_speed;
    logic [14:0] nom_volt;
    logic [19:0] arm_res, flux, inertia, drag;
    logic        snd_power, snd_pitch;
    logic signed [15:0] held_pitch;
    motor_result_t pending[$];
    int errors;
    int checked;

    function void reset_state();
      nom_speed = RstNomSpeed;
      nom_volt  = RstNomVolt;
      arm_res   = RstArmRes;
      flux      = RstFlux;
      inertia   = RstInertia;
      drag      = RstDrag;
      snd_power = 1'b0;
      snd_pitch = 1'b0;
      held_pitch = RstPitch;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegNomSpeed: nom_speed = data[20:0];
        RegNomVolt:  nom_volt  = data[14:0];
        RegArmRes:   arm_res   = data[19:0];
        RegFlux:     flux      = data[19:0];
        RegInertia:  inertia   = data[19:0];
        RegDrag:     drag      = data[19:0];
        RegSndPower: snd_power = data[0];
        RegSndPitch: snd_pitch = data[0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void note_input(logic signed [15:0] volt_in, logic signed [21:0] speed_in);
      longint u, w, om, cphi, num, cur, ma, mr, acc, wa;
      motor_result_t r;
      u  = volt_in;
      w  = speed_in;
      om = (nom_speed == 0) ? 1 : longint'(nom_speed);
      cphi = 0;
      if (u > 0) begin
        cphi = longint'((longint'(flux) * longint'(int_sqrt(
          longint'(u <<< 32) / ((nom_volt == 0) ? 1 : longint'(nom_volt))))) >>> 6);
      end
      num = u * (longint'(1) <<< 27) - cphi * w;
      cur = clamp(num / (((arm_res == 0) ? longint'(1) : longint'(arm_res)) <<< 12), 24);
      ma  = cphi * cur;
      wa  = (w < 0) ? -w : w;
      mr  = (longint'(drag) * wa * wa) >>> 12;
      if (w < 0) mr = -mr;
      acc = clamp((ma - mr) / (((inertia == 0) ? longint'(1) : longint'(inertia)) <<< 8), 32);
      if (snd_pitch) held_pitch = 16'(clamp((w * 8192) / om, 16));
      r.accel = 32'(acc);
      r.cur   = 24'(cur);
      r.pwr   = u > 0;
      r.rdy   = 10 * w > 9 * om;
      r.snd   = snd_power ? (u > 0) : (2 * w >= om);
      r.pitch = held_pitch;
      pending.push_back(r);
    endfunction

    function void check_result(motor_result_t got);
      motor_result_t exp_r;
      if (pending.size() == 0) begin
        $error("result item arrived with nothing expected");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got.accel !== exp_r.accel) begin
        $error("acceleration: expected %0d, got %0d", exp_r.accel, got.accel);
        errors++;
      end
      if (got.cur !== exp_r.cur) begin
        $error("current: expected %0d, got %0d", exp_r.cur, got.cur);
        errors++;
      end
      if (got.pwr !== exp_r.pwr) begin
        $error("powered: expected %0d, got %0d", exp_r.pwr, got.pwr);
        errors++;
      end
      if (got.rdy !== exp_r.rdy) begin
        $error("ready_res: expected %0d, got %0d", exp_r.rdy, got.rdy);
        errors++;
      end
      if (got.snd !== exp_r.snd) begin
        $error("sound_on: expected %0d, got %0d", exp_r.snd, got.snd);
        errors++;
      end
      if (got.pitch !== exp_r.pitch) begin
        $error("pitch: expected %0d, got %0d", exp_r.pitch, got.pitch);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_supply_voltage = '0;
  logic signed [21:0] in_rotor_speed = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_acceleration;
  logic signed [23:0] out_current;
  logic out_powered, out_ready_res, out_sound_on;
  logic signed [15:0] out_pitch;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  motor_scoreboard motor_sb = new();
  bit calm;
  bit held_done;
  int items_sent;

  always #4 clk = ~clk;

  dc_fan_motor_derivative i_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_supply_voltage, .in_rotor_speed,
    .out_valid, .out_stall, .out_acceleration, .out_current,
    .out_powered, .out_ready_res, .out_sound_on, .out_pitch,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      motor_sb.check_result({out_acceleration, out_current, out_powered,
                             out_ready_res, out_sound_on, out_pitch});
    end
  end

  // The receiver holds off once for a long stretch so that the block backs up.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!held_done && motor_sb.checked >= 60) begin
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk);
        held_done = 1'b1;
      end
      n = pick_gap();
      out_stall = (n != 0);
      if (n > 1) repeat (n - 1) @(negedge clk);
    end
  end

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    motor_sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Upper bits are filled with junk; the block must drop them.
  task automatic load_settings(logic [20:0] spd, logic [14:0] volt, logic [19:0] res,
                               logic [19:0] fl, logic [19:0] jn, logic [19:0] kf,
                               logic sp, logic pp);
    write_cfg(RegNomSpeed, {11'($urandom_range(0, 2047)), spd});
    write_cfg(RegNomVolt, {17'($urandom_range(0, 131071)), volt});
    write_cfg(RegArmRes, {12'($urandom_range(0, 4095)), res});
    write_cfg(RegFlux, {12'($urandom_range(0, 4095)), fl});
    write_cfg(RegInertia, {12'($urandom_range(0, 4095)), jn});
    write_cfg(RegDrag, {12'($urandom_range(0, 4095)), kf});
    write_cfg(RegSndPower, {31'($urandom_range(0, 32'h7fffffff)), sp});
    write_cfg(RegSndPitch, {31'($urandom_range(0, 32'h7fffffff)), pp});
    write_cfg(RegUnused, $urandom);
  endtask

  task automatic send_item(logic signed [15:0] volt, logic signed [21:0] spd);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_supply_voltage = volt;
    in_rotor_speed = spd;
    do @(posedge clk); while (in_stall);
    motor_sb.note_input(volt, spd);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      if (gap > 1) repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (motor_sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_volt();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return $signed(16'($urandom_range(0, 3))) - 16'sd1;
      2: return -$signed(16'($urandom_range(0, 32767)));
      default: return $signed(16'($urandom_range(0, 32767)));
    endcase
  endfunction

  function automatic logic signed [21:0] rand_speed();
    longint om, w;
    om = (motor_sb.nom_speed == 0) ? 1 : longint'(motor_sb.nom_speed);
    case ($urandom_range(0, 6))
      0: w = $urandom_range(0, 1) ? 2097151 : -2097152;
      1: w = (9 * om) / 10 + longint'($urandom_range(0, 4)) - 2;
      2: w = om / 2 + longint'($urandom_range(0, 4)) - 2;
      3: w = longint'($urandom_range(0, 2000)) - 1000;
      default: w = $signed(22'($urandom));
    endcase
    if (w > 2097151) w = 2097151;
    return 22'(w);
  endfunction

  initial begin
    logic [20:0] spd;
    repeat (12) @(posedge clk);
    motor_sb.reset_state();
    @(negedge clk);
    rst_n = 1'b1;

    // Directed items under reset settings: field extremes and flag thresholds.
    send_item(16'sh7fff, 22'sd0);
    send_item(16'sh8000, -22'sd2097152);
    send_item(16'sd0, 22'sd0);
    send_item(16'sd1, 22'sd1);
    send_item(-16'sd1, 22'sd2097151);
    send_item(16'sh7fff, 22'sd2097151);
    send_item(16'sh7fff, -22'sd2097152);
    send_item(16'sd12000, 22'sd173721);
    send_item(16'sd12000, 22'sd173722);
    send_item(16'sd96, 22'sd96511);
    send_item(16'sd96, 22'sd96512);
    drain();

    load_settings(21'd193024, 15'd12000, 20'd9421, 20'd7076, 20'd2048, 20'd4404, 1, 1);
    send_item(16'sd12000, 22'sd193024);
    send_item(16'sh7fff, 22'sd2097151);
    send_item(16'sh8000, -22'sd2097152);
    send_item(-16'sd5, 22'sd100);
    drain();

    for (int ph = 0; ph < NumRandPhases; ph++) begin
      calm = (ph == 3);
      case (ph)
        0: ;
        1: load_settings('1, '1, '1, '1, '1, '1, 1, 1);
        2: load_settings('0, '0, '0, '0, '0, '0, 0, 1);
        3: load_settings(21'd1, 15'd1, 20'd1, 20'd0, 20'd1, 20'd0, 1, 0);
        default: begin
          spd = $urandom_range(0, 1) ? 21'($urandom_range(1000, 400000)) : 21'($urandom);
          load_settings(spd, 15'($urandom_range(1, 32767)), 20'($urandom_range(1, 1048575)),
                        20'($urandom), 20'($urandom_range(1, 1048575)), 20'($urandom),
                        1'($urandom), 1'($urandom));
        end
      endcase
      repeat (RandPerPhase) send_item(rand_volt(), rand_speed());
      drain();
    end

    repeat (600) @(posedge clk);
    $display("Covered %0d items over eight register settings, with zero and full-scale",
             items_sent);
    $display("registers, both sound modes, held and refreshed pitch, and a long output hold.");
    if (motor_sb.errors == 0 && motor_sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/dcfm_pkg.sv
hw/rtl/dc_fan_motor_derivative.sv
verif/dc_fan_motor_derivative_test.sv
